### hw/rtl/tsb_pkg.sv
// Shared types and constants for the timer slot bank.
// Holds the channel payload structs, command and result codes, and the queued job format.
// No dependencies.
package tsb_pkg;

    localparam int DEF_NUM_SLOTS = 16;
    localparam int SLOT_OUT_W    = 4;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ADD  = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;

    localparam logic [2:0] KIND_FIRED     = 3'd0;
    localparam logic [2:0] KIND_ADDED     = 3'd1;
    localparam logic [2:0] KIND_FULL      = 3'd2;
    localparam logic [2:0] KIND_STOP_ACK  = 3'd3;
    localparam logic [2:0] KIND_TICK_DONE = 3'd4;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] elapsed_us;
        logic [31:0] lifespan_us;
        logic [31:0] owner_id;
        logic        owner_valid;
        logic        repeat_req;
    } t_in;

    typedef struct packed {
        logic [2:0]            kind;
        logic [SLOT_OUT_W-1:0] slot;
        logic [31:0]           fired_owner;
        logic                  fired_owner_valid;
        logic                  last;
    } t_out;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ADD  = 2'd1,
        OP_STOP = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] elapsed_us;
        logic [31:0] lifespan_us;
        logic [31:0] owner;
        logic        owner_valid;
        logic        repeat_mode;
    } t_job;

    typedef struct packed {
        logic        repeat_mode;
        logic [31:0] count;
        logic [31:0] target;
        logic [31:0] owner;
        logic        owner_valid;
    } t_entry;

endpackage

### hw/rtl/tsb_front.sv
// Front end of the timer slot bank: accepts commands, classifies them into jobs and queues them.
// Depends on tsb_pkg.
module tsb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tsb_pkg::t_in  i_data,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output tsb_pkg::t_job o_job
);
    import tsb_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    logic accept;
    logic push;
    logic pop;
    t_job job;

    // Unused command codes are accepted and dropped here.
    always_comb begin
        job             = '0;
        push            = 1'b0;
        job.elapsed_us  = i_data.elapsed_us;
        job.lifespan_us = i_data.lifespan_us;
        job.owner_valid = i_data.owner_valid;
        job.repeat_mode = i_data.repeat_req;
        unique case (i_data.command)
            CMD_TICK: begin
                job.op = OP_TICK;
                push   = accept;
            end
            CMD_ADD: begin
                job.op    = OP_ADD;
                job.owner = i_data.owner_valid ? i_data.owner_id : 32'd0;
                push      = accept;
            end
            CMD_STOP: begin
                job.op    = OP_STOP;
                job.owner = i_data.owner_id;
                push      = accept;
            end
            default: begin
                job.op = OP_TICK;
                push   = 1'b0;
            end
        endcase
    end

    assign o_ready     = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign accept      = i_valid && o_ready;
    assign o_job_valid = (r_count != '0);
    assign pop         = o_job_valid && i_job_ready;
    assign o_job       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= job;
        end
    end

endmodule

### hw/rtl/tsb_back.sv
// Back end of the timer slot bank: sweeps the slot memory one slot per cycle for each job,
// holding while a result waits; drives the registered result channel. Depends on tsb_pkg.
module tsb_back #(
    parameter int NUM_SLOTS = tsb_pkg::DEF_NUM_SLOTS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  tsb_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output tsb_pkg::t_out o_data
);
    import tsb_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SWEEP  = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [SLOT_W-1:0]     r_idx, n_idx;
    logic [NUM_SLOTS-1:0]  r_active, n_active;
    t_job                  r_job, n_job;
    t_entry                r_mem [NUM_SLOTS];
    t_entry                r_rd;
    t_out                  r_out;
    logic                  r_out_valid;

    logic                  rd_en;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  wr_en;
    t_entry                wr_data;
    logic                  emit;
    t_out                  emit_data;
    logic                  can_emit;
    logic                  advance;
    logic                  cur_active;
    logic [32:0]           sum;
    logic [31:0]           sat;
    logic                  fire;
    logic [SLOT_W+SLOT_OUT_W-1:0] idx_wide;

    assign can_emit   = !r_out_valid || i_ready;
    assign cur_active = r_active[r_idx];
    assign sum        = {1'b0, r_rd.count} + {1'b0, r_job.elapsed_us};
    assign sat        = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign fire       = (sat >= r_rd.target);
    assign idx_wide   = (SLOT_W + SLOT_OUT_W)'(r_idx);
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_active    = r_active;
        n_job       = r_job;
        rd_en       = 1'b0;
        rd_addr     = r_idx + SLOT_W'(1);
        wr_en       = 1'b0;
        wr_data     = r_rd;
        emit        = 1'b0;
        emit_data   = '0;
        o_job_ready = 1'b0;
        advance     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_ready = 1'b1;
                    n_job       = i_job;
                    n_idx       = '0;
                    rd_en       = 1'b1;
                    rd_addr     = '0;
                    n_state     = S_SWEEP;
                end
            end
            S_SWEEP: begin
                unique case (r_job.op)
                    OP_TICK: begin
                        if (!cur_active) begin
                            advance = 1'b1;
                        end else if (!fire) begin
                            wr_en         = 1'b1;
                            wr_data.count = sat;
                            advance       = 1'b1;
                        end else if (can_emit) begin
                            wr_en         = 1'b1;
                            wr_data.count = r_rd.repeat_mode ? 32'd0 : sat;
                            if (!r_rd.repeat_mode) begin
                                n_active[r_idx] = 1'b0;
                            end
                            emit                        = 1'b1;
                            emit_data.kind              = KIND_FIRED;
                            emit_data.slot              = idx_wide[SLOT_OUT_W-1:0];
                            emit_data.fired_owner       = r_rd.owner;
                            emit_data.fired_owner_valid = r_rd.owner_valid;
                            advance                     = 1'b1;
                        end
                    end
                    OP_STOP: begin
                        if (cur_active && r_rd.owner_valid && (r_rd.owner == r_job.owner)) begin
                            n_active[r_idx] = 1'b0;
                        end
                        advance = 1'b1;
                    end
                    OP_ADD: begin
                        if (cur_active) begin
                            advance = 1'b1;
                        end else if (can_emit) begin
                            wr_en               = 1'b1;
                            wr_data.repeat_mode = r_job.repeat_mode;
                            wr_data.count       = 32'd0;
                            wr_data.target      = r_job.lifespan_us;
                            wr_data.owner       = r_job.owner;
                            wr_data.owner_valid = r_job.owner_valid;
                            n_active[r_idx]     = 1'b1;
                            emit                = 1'b1;
                            emit_data.kind      = KIND_ADDED;
                            emit_data.slot      = idx_wide[SLOT_OUT_W-1:0];
                            emit_data.last      = 1'b1;
                            n_state             = S_IDLE;
                        end
                    end
                    default: begin
                        advance = 1'b1;
                    end
                endcase
                if (advance) begin
                    if (r_idx == SLOT_W'(NUM_SLOTS - 1)) begin
                        n_state = S_FINISH;
                    end else begin
                        n_idx = r_idx + SLOT_W'(1);
                        rd_en = 1'b1;
                    end
                end
            end
            S_FINISH: begin
                if (can_emit) begin
                    emit           = 1'b1;
                    emit_data.last = 1'b1;
                    unique case (r_job.op)
                        OP_ADD:  emit_data.kind = KIND_FULL;
                        OP_STOP: emit_data.kind = KIND_STOP_ACK;
                        default: emit_data.kind = KIND_TICK_DONE;
                    endcase
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_active <= n_active;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        if (emit) begin
            r_out <= emit_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

endmodule

### hw/rtl/timer_slot_bank_unit.sv
// Usage of the timer slot bank.
// The input channel (i_valid, o_ready, i_data) takes tick, add and stop commands. The
// output channel (o_valid, i_ready, o_data) returns results; the last one of a command
// has last set. An unused command code is taken and produces no result.
// A front end queues up to two commands while the back end works, so input is taken
// while a finished result still waits at the output register.
// The back end sweeps the slot memory one slot per cycle through a single read port,
// unless a result is held up. A tick or stop sweeps every slot; an add stops at the
// first free slot, or sweeps every slot when the bank is full.
// When the receiver stalls, the back end holds its place in the sweep until the
// result register is free, then continues with nothing lost.
// Reset clears all active flags, the queue and the output; slot contents are only used
// after an add has written them. Top level of the design; depends on tsb_pkg, tsb_front
// and tsb_back.
module timer_slot_bank_unit #(
    parameter int NUM_SLOTS = tsb_pkg::DEF_NUM_SLOTS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  tsb_pkg::t_in i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output tsb_pkg::t_out o_data
);
    import tsb_pkg::*;

    logic job_valid;
    logic job_ready;
    t_job job;

    tsb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    tsb_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

### dv/timer_slot_bank_unit_tb.sv
// Self-checking testbench for timer_slot_bank_unit: a directed table, then random tick,
// add, stop and unused commands, checked against a behavioral model of the slot bank.
// Depends on tsb_pkg and timer_slot_bank_unit.
module timer_slot_bank_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsb_pkg::*;

    localparam int SLOTS        = DEF_NUM_SLOTS;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int IDLE_PCT     = 11;
    localparam int RANDOM_ITEMS = 195;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 40;
    localparam int DIR_ROWS     = 25;
    localparam int TIMEOUT_NS   = 3_000_000;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        t_in  item;
        logic typed;
        t_out want;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    logic        live_flag   [SLOTS];
    logic        recur_flag  [SLOTS];
    logic [31:0] elapsed_acc [SLOTS];
    logic [31:0] fire_at     [SLOTS];
    logic [31:0] tag_value   [SLOTS];
    logic        tag_ok      [SLOTS];

    t_out     step_q[$];
    t_out     expected_q[$];
    dir_row_t dir_tab[DIR_ROWS];

    bit hold_req = 1'b0;
    bit calm     = 1'b0;
    int err_count = 0;
    int results_checked = 0;
    int holds_done = 0;
    int n_tick = 0;
    int n_add = 0;
    int n_stop = 0;
    int n_unused = 0;
    int n_fire = 0;
    int n_full = 0;

    timer_slot_bank_unit #(
        .NUM_SLOTS(SLOTS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_out make_result(logic [2:0] kind, int slot, logic [31:0] owner,
                                         logic owner_ok, logic last);
        t_out r;
        r.kind              = kind;
        r.slot              = SLOT_OUT_W'(slot);
        r.fired_owner       = owner;
        r.fired_owner_valid = owner_ok;
        r.last              = last;
        return r;
    endfunction

    function automatic dir_row_t mk_row(logic [1:0] cmd, logic [31:0] elapsed,
                                        logic [31:0] life, logic [31:0] owner,
                                        logic owner_ok, logic rep, logic typed,
                                        logic [2:0] kind, int slot);
        dir_row_t row;
        row.item.command     = cmd;
        row.item.elapsed_us  = elapsed;
        row.item.lifespan_us = life;
        row.item.owner_id    = owner;
        row.item.owner_valid = owner_ok;
        row.item.repeat_req  = rep;
        row.typed            = typed;
        row.want             = typed ? make_result(kind, slot, '0, 1'b0, 1'b1) : '0;
        return row;
    endfunction

    task automatic predict_command(input t_in cmd);
        logic [32:0] total;
        logic [31:0] now_count;
        int          s;
        int          free_slot;
        step_q.delete();
        case (cmd.command)
            CMD_TICK: begin
                n_tick++;
                for (s = 0; s < SLOTS; s++) begin
                    if (live_flag[s]) begin
                        total = {1'b0, elapsed_acc[s]} + {1'b0, cmd.elapsed_us};
                        now_count = total[32] ? 32'hFFFF_FFFF : total[31:0];
                        elapsed_acc[s] = now_count;
                        if (now_count >= fire_at[s]) begin
                            n_fire++;
                            step_q.push_back(make_result(KIND_FIRED, s,
                                tag_ok[s] ? tag_value[s] : 32'd0, tag_ok[s], 1'b0));
                            if (recur_flag[s]) begin
                                elapsed_acc[s] = '0;
                            end else begin
                                live_flag[s] = 1'b0;
                            end
                        end
                    end
                end
                step_q.push_back(make_result(KIND_TICK_DONE, 0, '0, 1'b0, 1'b1));
            end
            CMD_ADD: begin
                n_add++;
                free_slot = -1;
                for (s = 0; s < SLOTS; s++) begin
                    if (!live_flag[s] && free_slot < 0) begin
                        free_slot = s;
                    end
                end
                if (free_slot < 0) begin
                    n_full++;
                    step_q.push_back(make_result(KIND_FULL, 0, '0, 1'b0, 1'b1));
                end else begin
                    live_flag[free_slot]   = 1'b1;
                    recur_flag[free_slot]  = cmd.repeat_req;
                    elapsed_acc[free_slot] = '0;
                    fire_at[free_slot]     = cmd.lifespan_us;
                    tag_value[free_slot]   = cmd.owner_valid ? cmd.owner_id : 32'd0;
                    tag_ok[free_slot]      = cmd.owner_valid;
                    step_q.push_back(make_result(KIND_ADDED, free_slot, '0, 1'b0, 1'b1));
                end
            end
            CMD_STOP: begin
                n_stop++;
                for (s = 0; s < SLOTS; s++) begin
                    if (live_flag[s] && tag_ok[s] && tag_value[s] == cmd.owner_id) begin
                        live_flag[s] = 1'b0;
                    end
                end
                step_q.push_back(make_result(KIND_STOP_ACK, 0, '0, 1'b0, 1'b1));
            end
            default: begin
                n_unused++;
            end
        endcase
    endtask

    function automatic logic [31:0] pick_owner();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return 32'($urandom_range(0, 15));
        if (roll < 90) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic t_in random_command();
        t_in c;
        int  roll;
        int  pick;
        c.elapsed_us  = $urandom;
        c.lifespan_us = $urandom;
        c.owner_id    = $urandom;
        c.owner_valid = 1'($urandom);
        c.repeat_req  = 1'($urandom);
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        if (roll < 5) begin
            c.command = CMD_UNUSED;
        end else if (roll < 45) begin
            c.command = CMD_TICK;
            if (pick < 70) begin
                c.elapsed_us = 32'($urandom_range(0, 20));
            end else if (pick < 80) begin
                c.elapsed_us = '0;
            end else if (pick < 90) begin
                c.elapsed_us = 32'hFFFF_FFFF;
            end
        end else if (roll < 80) begin
            c.command = CMD_ADD;
            if (pick < 75) begin
                c.lifespan_us = 32'($urandom_range(0, 40));
            end else if (pick < 85) begin
                c.lifespan_us = '0;
            end else if (pick < 90) begin
                c.lifespan_us = 32'hFFFF_FFFF;
            end
            c.owner_id    = pick_owner();
            c.owner_valid = ($urandom_range(0, 99) < 85);
            if (!c.owner_valid) begin
                c.repeat_req = ($urandom_range(0, 9) == 0);
            end
        end else begin
            c.command  = CMD_STOP;
            c.owner_id = pick_owner();
        end
        return c;
    endfunction

    task automatic send_command(input t_in cmd, input logic typed, input t_out want);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= cmd;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_command(cmd);
        if (typed) begin
            expected_q.push_back(want);
        end else begin
            foreach (step_q[j]) expected_q.push_back(step_q[j]);
        end
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n === 1'b1 && o_valid && i_ready) begin
            results_checked++;
            if (expected_q.size() == 0) begin
                $display("%0t ns: unexpected transaction, expected none, %s %0d slot %0d",
                         $time, "actual kind", o_data.kind, o_data.slot);
                err_count++;
            end else begin
                want = expected_q.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_data.kind));
                check_field("slot", 32'(want.slot), 32'(o_data.slot));
                check_field("fired_owner", want.fired_owner, o_data.fired_owner);
                check_field("fired_owner_valid", 32'(want.fired_owner_valid),
                            32'(o_data.fired_owner_valid));
                check_field("last", 32'(want.last), 32'(o_data.last));
            end
        end
    end

    initial begin
        i_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                holds_done++;
                repeat (HOLD_CYCLES) begin
                    i_ready <= 1'b0;
                    @(negedge i_clk);
                end
            end else begin
                i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
                @(negedge i_clk);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Run timed out with %0d results outstanding.", expected_q.size());
        $display("timer_slot_bank_unit_tb: errors");
        $finish;
    end

    initial begin
        t_in cmd;
        int  r;
        int  k;
        int  sent;
        int  iter;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        for (k = 0; k < SLOTS; k++) begin
            live_flag[k]   = 1'b0;
            recur_flag[k]  = 1'b0;
            elapsed_acc[k] = '0;
            fire_at[k]     = '0;
            tag_value[k]   = '0;
            tag_ok[k]      = 1'b0;
        end

        dir_tab[0] = mk_row(CMD_TICK, '0, '0, '0, 1'b0, 1'b0, 1'b1, KIND_TICK_DONE, 0);
        dir_tab[1] = mk_row(CMD_STOP, '1, '1, '0, 1'b1, 1'b1, 1'b1, KIND_STOP_ACK, 0);
        dir_tab[2] = mk_row(CMD_UNUSED, '1, '1, '1, 1'b1, 1'b1, 1'b0, KIND_FIRED, 0);
        dir_tab[3] = mk_row(CMD_ADD, '0, '0, '1, 1'b0, 1'b1, 1'b1, KIND_ADDED, 0);
        dir_tab[4] = mk_row(CMD_ADD, '0, '1, '1, 1'b1, 1'b0, 1'b1, KIND_ADDED, 1);
        dir_tab[5] = mk_row(CMD_ADD, '1, 32'd5, '0, 1'b1, 1'b1, 1'b1, KIND_ADDED, 2);
        for (k = 3; k < SLOTS; k++) begin
            dir_tab[k + 3] = mk_row(CMD_ADD, 32'hDEAD_0000 | 32'(k), 32'(k) * 3,
                                    (k % 4 >= 2) ? 32'hFFFF_FFFF : 32'(k),
                                    (k % 4 != 0), 1'(k), 1'b1, KIND_ADDED, k);
        end
        dir_tab[19] = mk_row(CMD_ADD, '0, 32'd7, 32'd1, 1'b1, 1'b0, 1'b1, KIND_FULL, 0);
        dir_tab[20] = mk_row(CMD_TICK, '0, '1, '1, 1'b1, 1'b1, 1'b0, KIND_FIRED, 0);
        dir_tab[21] = mk_row(CMD_TICK, 32'h8000_0000, '0, '0, 1'b0, 1'b0, 1'b0,
                             KIND_FIRED, 0);
        dir_tab[22] = mk_row(CMD_TICK, 32'h8000_0000, '0, '0, 1'b0, 1'b0, 1'b0,
                             KIND_FIRED, 0);
        dir_tab[23] = mk_row(CMD_STOP, '0, '0, '1, 1'b0, 1'b0, 1'b1, KIND_STOP_ACK, 0);
        dir_tab[24] = mk_row(CMD_TICK, '1, '0, '0, 1'b0, 1'b0, 1'b0, KIND_FIRED, 0);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (r = 0; r < DIR_ROWS; r++) begin
            send_command(dir_tab[r].item, dir_tab[r].typed, dir_tab[r].want);
        end

        sent = 0;
        iter = 0;
        while (sent < RANDOM_ITEMS) begin
            calm = (sent >= 90 && sent < 150);
            if (iter == 30 || iter == 175) begin
                hold_req = 1'b1;
            end
            cmd = random_command();
            send_command(cmd, 1'b0, '0);
            if (cmd.command != CMD_UNUSED) begin
                sent++;
            end
            iter++;
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d ticks, %0d adds, %0d stops and %0d unused codes; %0d holds.",
                 n_tick, n_add, n_stop, n_unused, holds_done);
        $display("Checked %0d result transactions, %0d fire events, %0d bank-full replies.",
                 results_checked, n_fire, n_full);
        if (err_count == 0) begin
            $display("timer_slot_bank_unit_tb: clean");
        end else begin
            $display("timer_slot_bank_unit_tb: errors");
        end
        $finish;
    end

endmodule
